// ----- src/glos_pkg.sv -----
// Shared types and constants for the grid line-of-sight block.
`timescale 1ns / 1ps

package glos_pkg;

	// Fixed field widths of a transaction
	localparam int CX_W = 6;
	localparam int CY_W = 6;
	localparam int CZ_W = 4;
	// Distances along any axis fit the widest coordinate
	localparam int D_W  = 6;
	// Bresenham error term, signed, with headroom for the doubled compare
	localparam int E_W  = D_W + 3;

	// Input transaction payload
	typedef struct packed {
		logic            kind;
		logic [CX_W-1:0] x_a;
		logic [CY_W-1:0] y_a;
		logic [CZ_W-1:0] z_a;
		logic [CX_W-1:0] x_b;
		logic [CY_W-1:0] y_b;
		logic [CZ_W-1:0] z_b;
		logic            cell_present;
		logic            cell_blocks;
		logic            require_same_floor;
	} req_item_t;

	// Kind codes
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // capture the input transaction
		logic wr_cell;   // store the captured cell bits
		logic clr_wr;    // clear one cell and advance the sweep
		logic ray_init;  // set up a ray
		logic ray_sel;   // 0: a to b, 1: b to a
		logic rd_floor;  // read the lower cell under the last point
		logic rd_cell;   // read the current cell, move last point here
		logic adv;       // take one Bresenham step
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_query;
		logic floor_mismatch;
		logic probe;
		logic floor_chg;
		logic last_visit;
		logic present_hit;
		logic block_hit;
		logic clr_last;
	} sts_t;

endpackage

// ----- src/glos_req_if.sv -----
// Request channel: valid/ready handshake with the query or write payload.
`timescale 1ns / 1ps

interface glos_req_if;
	import glos_pkg::*;

	logic            valid;
	logic            ready;
	logic            kind;
	logic [CX_W-1:0] x_a;
	logic [CY_W-1:0] y_a;
	logic [CZ_W-1:0] z_a;
	logic [CX_W-1:0] x_b;
	logic [CY_W-1:0] y_b;
	logic [CZ_W-1:0] z_b;
	logic            cell_present;
	logic            cell_blocks;
	logic            require_same_floor;

	modport source (
		output valid, kind, x_a, y_a, z_a, x_b, y_b, z_b,
		       cell_present, cell_blocks, require_same_floor,
		input  ready
	);

	modport sink (
		input  valid, kind, x_a, y_a, z_a, x_b, y_b, z_b,
		       cell_present, cell_blocks, require_same_floor,
		output ready
	);

endinterface

// ----- src/glos_rsp_if.sv -----
// Response channel: valid/ready handshake carrying the sight answer.
`timescale 1ns / 1ps

interface glos_rsp_if;

	logic valid;
	logic ready;
	logic sight_clear;

	modport source (
		output valid, sight_clear,
		input  ready
	);

	modport sink (
		input  valid, sight_clear,
		output ready
	);

endinterface

// ----- src/glos_ctrl.sv -----
// Controller state machine: clearing sweep, decode, ray sequencing, result register.
`timescale 1ns / 1ps

module glos_ctrl
	import glos_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output logic rsp_clear,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_STEP,
		S_RD_FLOOR,
		S_RD_CELL,
		S_DONE
	} state_t;

	state_t state_q;
	logic   sel_q;        // which ray is running
	logic   res_q;        // answer waiting for the output register
	logic   rsp_valid_q;
	logic   rsp_clear_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_clear = rsp_clear_q;

	// Command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_DECODE: begin
				if (!sts.is_query) begin
					cmd.wr_cell = 1'b1;
				end else if (!sts.floor_mismatch) begin
					cmd.ray_init = 1'b1;
					cmd.ray_sel  = 1'b0;
				end
			end
			S_STEP: begin
				if (sts.probe) begin
					if (sts.floor_chg)
						cmd.rd_floor = 1'b1;
					else
						cmd.rd_cell = 1'b1;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			S_RD_FLOOR: begin
				if (sts.present_hit) begin
					if (!sel_q) begin
						cmd.ray_init = 1'b1;
						cmd.ray_sel  = 1'b1;
					end
				end else begin
					cmd.rd_cell = 1'b1;
				end
			end
			S_RD_CELL: begin
				if (sts.block_hit) begin
					if (!sel_q) begin
						cmd.ray_init = 1'b1;
						cmd.ray_sel  = 1'b1;
					end
				end else begin
					cmd.adv = 1'b1;
				end
			end
			S_DONE: begin
				cmd = '0;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sel_q       <= 1'b0;
			res_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_clear_q <= 1'b0;
		end else begin
			// output register empties on a taken response; the result state refills it
			if (rsp_valid_q && rsp_ready && state_q != S_DONE)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid)
						state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (!sts.is_query) begin
						state_q <= S_IDLE;
					end else if (sts.floor_mismatch) begin
						res_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						sel_q   <= 1'b0;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (sts.probe) begin
						state_q <= sts.floor_chg ? S_RD_FLOOR : S_RD_CELL;
					end else if (sts.last_visit) begin
						res_q   <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_RD_FLOOR: begin
					if (sts.present_hit) begin
						// ray blocked: try the reverse ray, or give up
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= S_STEP;
						end else begin
							res_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_RD_CELL;
					end
				end
				S_RD_CELL: begin
					if (sts.block_hit) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= S_STEP;
						end else begin
							res_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end else if (sts.last_visit) begin
						res_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						rsp_clear_q <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// An accepted transaction is always decoded next
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_DECODE))
		else $error("accepted transaction not decoded");

	// A response only appears from the result state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == S_DONE))
		else $error("response raised outside result state");

	// A finished answer waits while the output register is still occupied
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid && !rsp_ready) |=> (state_q == S_DONE))
		else $error("result dropped while output stalled");

endmodule

// ----- src/glos_dp.sv -----
// Datapath: cell memory, captured transaction, Bresenham ray registers.
`timescale 1ns / 1ps

module glos_dp
	import glos_pkg::*;
#(
	parameter int X_SIZE = 64,
	parameter int Y_SIZE = 64,
	parameter int Z_SIZE = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t item,
	input  cmd_t      cmd,
	output sts_t      sts
);

	localparam int    XW    = $clog2(X_SIZE);
	localparam int    YW    = $clog2(Y_SIZE);
	localparam int    ZW    = (Z_SIZE > 1) ? $clog2(Z_SIZE) : 1;
	localparam int    AW    = XW + YW + ZW;
	localparam longint DEPTH = longint'(1) << AW;

	typedef struct packed {
		logic [CX_W-1:0] x;
		logic [CY_W-1:0] y;
		logic [CZ_W-1:0] z;
	} pt_t;

	typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} ax_t;

	// Cell memory: bit 0 present, bit 1 blocks
	logic [1:0]    mem_q [DEPTH];
	logic [1:0]    rdata_q;
	logic          rvalid_q;
	logic [AW-1:0] clr_q;

	// Captured transaction
	pt_t  a_q, b_q;
	logic kind_q, rsf_q, pres_q, blk_q;

	// Ray state
	pt_t                    p_q, last_q;
	logic                   sx_q, sy_q, sz_q;   // 1 steps downwards
	ax_t                    m_q, n1_q, n2_q;
	logic [D_W-1:0]         dm_q, dn1_q, dn2_q, cnt_q;
	logic signed [E_W-1:0]  err1_q, err2_q;

	function automatic logic [AW-1:0] cell_addr(pt_t c);
		logic [15:0] xw, yw, zw;
		xw = 16'(c.x);
		yw = 16'(c.y);
		zw = 16'(c.z);
		return {zw[ZW-1:0], yw[YW-1:0], xw[XW-1:0]};
	endfunction

	function automatic logic in_grid(pt_t c);
		return (17'(c.x) < 17'(X_SIZE)) && (17'(c.y) < 17'(Y_SIZE)) &&
		       (17'(c.z) < 17'(Z_SIZE));
	endfunction

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= item.kind;
			a_q    <= '{x: item.x_a, y: item.y_a, z: item.z_a};
			b_q    <= '{x: item.x_b, y: item.y_b, z: item.z_b};
			pres_q <= item.cell_present;
			blk_q  <= item.cell_blocks;
			rsf_q  <= item.require_same_floor;
		end
	end

	// Ray set-up: distances, directions and major axis
	pt_t            s_pt, e_pt;
	logic [CX_W-1:0] ddx;
	logic [CY_W-1:0] ddy;
	logic [CZ_W-1:0] ddz;
	logic [D_W-1:0]  dxe, dye, dze;
	ax_t            mi, n1i, n2i;
	logic [D_W-1:0]  dmi, dn1i, dn2i;

	always_comb begin
		s_pt = cmd.ray_sel ? b_q : a_q;
		e_pt = cmd.ray_sel ? a_q : b_q;
		ddx  = (s_pt.x > e_pt.x) ? s_pt.x - e_pt.x : e_pt.x - s_pt.x;
		ddy  = (s_pt.y > e_pt.y) ? s_pt.y - e_pt.y : e_pt.y - s_pt.y;
		ddz  = (s_pt.z > e_pt.z) ? s_pt.z - e_pt.z : e_pt.z - s_pt.z;
		dxe  = D_W'(ddx);
		dye  = D_W'(ddy);
		dze  = D_W'(ddz);
		// ties go to x, then z over y
		if (dze > dxe && dze >= dye) begin
			mi = AX_Z; n1i = AX_X; n2i = AX_Y;
			dmi = dze; dn1i = dxe; dn2i = dye;
		end else if (dye > dxe) begin
			mi = AX_Y; n1i = AX_X; n2i = AX_Z;
			dmi = dye; dn1i = dxe; dn2i = dze;
		end else begin
			mi = AX_X; n1i = AX_Y; n2i = AX_Z;
			dmi = dxe; dn1i = dye; dn2i = dze;
		end
	end

	// One Bresenham step
	logic signed [E_W-1:0] e1n, e2n, dm_s;
	logic signed [E_W:0]   e1x2, e2x2, dm_w;
	logic                  st1, st2, incx, incy, incz;

	always_comb begin
		dm_s = $signed({3'b000, dm_q});
		dm_w = $signed({4'b0000, dm_q});
		e1n  = err1_q + $signed({3'b000, dn1_q});
		e2n  = err2_q + $signed({3'b000, dn2_q});
		e1x2 = {e1n, 1'b0};
		e2x2 = {e2n, 1'b0};
		st1  = (e1x2 >= dm_w);
		st2  = (e2x2 >= dm_w);
		incx = (m_q == AX_X) || (n1_q == AX_X && st1) || (n2_q == AX_X && st2);
		incy = (m_q == AX_Y) || (n1_q == AX_Y && st1) || (n2_q == AX_Y && st2);
		incz = (m_q == AX_Z) || (n1_q == AX_Z && st1) || (n2_q == AX_Z && st2);
	end

	// Ray registers
	always_ff @(posedge clk) begin
		if (cmd.ray_init) begin
			p_q    <= s_pt;
			last_q <= s_pt;
			sx_q   <= (s_pt.x >= e_pt.x);
			sy_q   <= (s_pt.y >= e_pt.y);
			sz_q   <= (s_pt.z >= e_pt.z);
			m_q    <= mi;
			n1_q   <= n1i;
			n2_q   <= n2i;
			dm_q   <= dmi;
			dn1_q  <= dn1i;
			dn2_q  <= dn2i;
			cnt_q  <= dmi;
			err1_q <= '0;
			err2_q <= '0;
		end else begin
			if (cmd.rd_cell)
				last_q <= p_q;
			if (cmd.adv) begin
				err1_q <= st1 ? e1n - dm_s : e1n;
				err2_q <= st2 ? e2n - dm_s : e2n;
				if (incx)
					p_q.x <= sx_q ? p_q.x - 1'b1 : p_q.x + 1'b1;
				if (incy)
					p_q.y <= sy_q ? p_q.y - 1'b1 : p_q.y + 1'b1;
				if (incz)
					p_q.z <= sz_q ? p_q.z - 1'b1 : p_q.z + 1'b1;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Read address: floor probe under the last point, or the current cell
	pt_t             rd_pt;
	logic [CZ_W-1:0] low_z;
	logic            wr_en;

	always_comb begin
		low_z = (last_q.z < p_q.z) ? last_q.z : p_q.z;
		if (cmd.rd_floor)
			rd_pt = '{x: last_q.x, y: last_q.y, z: low_z};
		else
			rd_pt = p_q;
		wr_en = cmd.wr_cell && in_grid(a_q);
	end

	// Memory write port: clearing sweep or cell write
	always_ff @(posedge clk) begin
		if (cmd.clr_wr)
			mem_q[clr_q] <= 2'b00;
		else if (wr_en)
			mem_q[cell_addr(a_q)] <= {blk_q, pres_q};
	end

	// Memory read port, registered; outside the grid reads as empty
	always_ff @(posedge clk) begin
		if (cmd.rd_floor || cmd.rd_cell) begin
			rdata_q  <= mem_q[cell_addr(rd_pt)];
			rvalid_q <= in_grid(rd_pt);
		end
	end

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clr_wr)
			clr_q <= clr_q + 1'b1;
	end

	// Status
	logic at_o, at_d, floor_chg;

	always_comb begin
		at_o                = (p_q == a_q);
		at_d                = (p_q == b_q);
		floor_chg           = (last_q.z != p_q.z);
		sts.is_query        = (kind_q == KIND_QUERY);
		sts.floor_mismatch  = rsf_q && (a_q.z != b_q.z);
		sts.floor_chg       = floor_chg;
		sts.probe           = floor_chg || (!at_o && !at_d);
		sts.last_visit      = (cnt_q == '0);
		sts.present_hit     = rvalid_q && rdata_q[0];
		sts.block_hit       = rvalid_q && (rdata_q == 2'b11);
		sts.clr_last        = &clr_q;
	end

	// Only one memory read per cycle
	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_floor && cmd.rd_cell))
		else $error("floor and cell read issued together");

	// No transaction is captured while the clearing sweep runs
	a_no_load_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !cmd.load)
		else $error("transaction captured during clearing sweep");

	// A ray is never set up in the same cycle as a step
	a_init_not_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ray_init |-> !cmd.adv)
		else $error("ray set-up and step issued together");

endmodule

// ----- src/grid_line_of_sight_3d.sv -----
// Top level of the 3D grid line-of-sight block.
`timescale 1ns / 1ps

// Usage:
//   req carries one transaction per valid/ready handshake. kind = write stores
//   cell_present and cell_blocks at (x_a, y_a, z_a); writes outside the grid
//   are dropped and produce no response. kind = query asks whether the sight
//   line between (x_a, y_a, z_a) and (x_b, y_b, z_b) is clear, and gives one
//   rsp transaction carrying sight_clear.
//   A write is stored after its decode. A query is decoded, then each ray
//   steps cell by cell: endpoint cells are skipped unless the floor changes,
//   other cells are read through the cell memory's single read port, and
//   a floor change first reads the lower cell under the last point. A ray is
//   up to 64 cells; the reverse ray runs only when the first is blocked. A
//   query with same-floor checking and differing floors is answered without a ray.
//   One transaction is in work at a time; req is ready again once the answer
//   sits in the output register, so the next request is taken while rsp waits.
//   If rsp stalls with an answer held, a further query finishes its rays and
//   waits until the output register frees up.
//   Reset: after arst_n releases, a clearing pass sweeps every memory row,
//   2**(clog2(X_SIZE)+clog2(Y_SIZE)+clog2(Z_SIZE)) rows (65536 at the
//   default size); req stays not ready until it ends.

module grid_line_of_sight_3d
	import glos_pkg::*;
#(
	parameter int X_SIZE = 64,
	parameter int Y_SIZE = 64,
	parameter int Z_SIZE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	glos_req_if.sink   req,
	glos_rsp_if.source rsp
);

	req_item_t item;
	cmd_t      cmd;
	sts_t      sts;
	logic      ctrl_req_ready;
	logic      ctrl_rsp_valid;
	logic      ctrl_rsp_clear;

	// Pack the request payload
	always_comb begin
		item.kind               = req.kind;
		item.x_a                = req.x_a;
		item.y_a                = req.y_a;
		item.z_a                = req.z_a;
		item.x_b                = req.x_b;
		item.y_b                = req.y_b;
		item.z_b                = req.z_b;
		item.cell_present       = req.cell_present;
		item.cell_blocks        = req.cell_blocks;
		item.require_same_floor = req.require_same_floor;
	end

	assign req.ready       = ctrl_req_ready;
	assign rsp.valid       = ctrl_rsp_valid;
	assign rsp.sight_clear = ctrl_rsp_clear;

	glos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ctrl_req_ready),
		.rsp_valid (ctrl_rsp_valid),
		.rsp_ready (rsp.ready),
		.rsp_clear (ctrl_rsp_clear),
		.cmd       (cmd),
		.sts       (sts)
	);

	glos_dp #(
		.X_SIZE (X_SIZE),
		.Y_SIZE (Y_SIZE),
		.Z_SIZE (Z_SIZE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for grid_line_of_sight_3d: directed table, then random scenes.
`timescale 1ns / 1ps

module tb_top;
	import glos_pkg::*;

	localparam int CELL_AW        = CX_W + CY_W + CZ_W;
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int SETTLE_CYCLES  = 400;
	localparam int RANDOM_ITEMS   = 600;
	localparam int PAUSE_EVERY    = 200;
	localparam int REPORT_MAX     = 10;
	localparam int PRESENT_BIT    = 0;
	localparam int BLOCKS_BIT     = 1;

	// How an answer is judged: from the predictor, or a value known up front
	typedef enum logic [1:0] {CHK_MODEL, CHK_CLEAR, CHK_BLOCKED} chk_t;

	// Receiver behaviour for one stretch of cycles
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_HOLD, RX_SPARSE} stall_t;

	typedef struct packed {
		logic [CX_W-1:0] x;
		logic [CY_W-1:0] y;
		logic [CZ_W-1:0] z;
	} point_t;

	typedef struct {
		req_item_t item;
		chk_t      how;
	} stim_row_t;

	typedef struct {
		req_item_t query;
		logic      clear;
	} sight_exp_t;

	logic clk;
	logic arst_n;

	glos_req_if req_ch ();
	glos_rsp_if rsp_ch ();

	grid_line_of_sight_3d DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow of the cell memory: bit 0 present, bit 1 blocks
	logic [1:0] cell_map [0:(1 << CELL_AW) - 1];
	sight_exp_t sight_q [$];
	chk_t       check_q [$];
	stim_row_t  directed_q [$];
	int         mismatch_cnt = 0;
	int         idle_cycles  = 0;
	int         burst_left   = 0;
	int         random_sent  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic req_item_t pack_item(input logic kind, input int xa, ya, za, xb, yb, zb,
			input logic present, blocks, same_floor);
		req_item_t r;
		r.kind               = kind;
		r.x_a                = xa[CX_W-1:0];
		r.y_a                = ya[CY_W-1:0];
		r.z_a                = za[CZ_W-1:0];
		r.x_b                = xb[CX_W-1:0];
		r.y_b                = yb[CY_W-1:0];
		r.z_b                = zb[CZ_W-1:0];
		r.cell_present       = present;
		r.cell_blocks        = blocks;
		r.require_same_floor = same_floor;
		return r;
	endfunction

	// Append one row to the directed table
	function automatic void add_row(input req_item_t it, input chk_t how);
		stim_row_t row;
		row.item   = it;
		row.how    = how;
		directed_q = {directed_q, row};
	endfunction

	function automatic logic [CELL_AW-1:0] cell_addr(input int x, input int y, input int z);
		return {z[CZ_W-1:0], y[CY_W-1:0], x[CX_W-1:0]};
	endfunction

	// Trace one Bresenham ray; org and dst are the query endpoints, skipped unless floor moves
	function automatic logic ray_unobstructed(input point_t from_pt, input point_t to_pt,
			input point_t org, input point_t dst);
		int         beg [3];
		int         fin [3];
		int         span [3];
		int         dir [3];
		int         pos [3];
		int         prev [3];
		int         maj, mn1, mn2, acc1, acc2, k, low_z;
		logic       at_end;
		logic [1:0] bits;
		beg = '{int'(from_pt.x), int'(from_pt.y), int'(from_pt.z)};
		fin = '{int'(to_pt.x), int'(to_pt.y), int'(to_pt.z)};
		for (k = 0; k < 3; k++) begin
			span[k] = beg[k] > fin[k] ? beg[k] - fin[k] : fin[k] - beg[k];
			dir[k]  = beg[k] < fin[k] ? 1 : -1;
			pos[k]  = beg[k];
			prev[k] = beg[k];
		end
		// longest axis leads; on a tie x wins, then z ahead of y
		if (span[2] > span[0] && span[2] >= span[1]) begin
			maj = 2; mn1 = 0; mn2 = 1;
		end else if (span[1] > span[0]) begin
			maj = 1; mn1 = 0; mn2 = 2;
		end else begin
			maj = 0; mn1 = 1; mn2 = 2;
		end
		acc1 = 0;
		acc2 = 0;
		for (k = 0; k <= span[maj]; k++) begin
			at_end = (pos[0] == org.x && pos[1] == org.y && pos[2] == org.z) ||
			         (pos[0] == dst.x && pos[1] == dst.y && pos[2] == dst.z);
			if (prev[2] != pos[2] || !at_end) begin
				// floor change: any tile on the lower floor under the last point stops it
				if (prev[2] != pos[2]) begin
					low_z = prev[2] < pos[2] ? prev[2] : pos[2];
					bits  = cell_map[cell_addr(prev[0], prev[1], low_z)];
					if (bits[PRESENT_BIT])
						return 1'b0;
				end
				prev = pos;
				bits = cell_map[cell_addr(pos[0], pos[1], pos[2])];
				if (bits[PRESENT_BIT] && bits[BLOCKS_BIT])
					return 1'b0;
			end
			acc1 += span[mn1];
			acc2 += span[mn2];
			if (2 * acc1 >= span[maj]) begin
				pos[mn1] += dir[mn1];
				acc1     -= span[maj];
			end
			if (2 * acc2 >= span[maj]) begin
				pos[mn2] += dir[mn2];
				acc2     -= span[maj];
			end
			pos[maj] += dir[maj];
		end
		return 1'b1;
	endfunction

	function automatic logic sight_predict(input req_item_t q);
		point_t pa;
		point_t pb;
		pa = {q.x_a, q.y_a, q.z_a};
		pb = {q.x_b, q.y_b, q.z_b};
		if (q.require_same_floor && q.z_a != q.z_b)
			return 1'b0;
		return ray_unobstructed(pa, pb, pa, pb) || ray_unobstructed(pb, pa, pa, pb);
	endfunction

	// Response check, then request tracking and the no-progress watchdog
	always @(posedge clk) begin : scoreboard
		sight_exp_t ent;
		req_item_t  it;
		chk_t       how;
		logic       rsp_fire;
		logic       req_fire;
		rsp_fire = rsp_ch.valid && rsp_ch.ready;
		req_fire = req_ch.valid && req_ch.ready;
		if (rsp_fire) begin
			if (sight_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_MAX)
					$display("%0t: response with nothing outstanding, sight_clear=%0b",
						$realtime, rsp_ch.sight_clear);
			end else begin
				ent = sight_q.pop_front();
				if (rsp_ch.sight_clear !== ent.clear) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_MAX)
						$display("%0t: (%0d,%0d,%0d)->(%0d,%0d,%0d) same_floor=%0b: exp %0b got %0b",
							$realtime, ent.query.x_a, ent.query.y_a, ent.query.z_a,
							ent.query.x_b, ent.query.y_b, ent.query.z_b,
							ent.query.require_same_floor, ent.clear, rsp_ch.sight_clear);
				end
			end
		end
		if (req_fire) begin
			it  = {req_ch.kind, req_ch.x_a, req_ch.y_a, req_ch.z_a, req_ch.x_b, req_ch.y_b,
			       req_ch.z_b, req_ch.cell_present, req_ch.cell_blocks,
			       req_ch.require_same_floor};
			how = check_q.pop_front();
			if (it.kind == KIND_WRITE) begin
				cell_map[cell_addr(it.x_a, it.y_a, it.z_a)] = {it.cell_blocks, it.cell_present};
			end else begin
				ent.query = it;
				case (how)
					CHK_CLEAR:   ent.clear = 1'b1;
					CHK_BLOCKED: ent.clear = 1'b0;
					default:     ent.clear = sight_predict(it);
				endcase
				sight_q = {sight_q, ent};
			end
		end
		if (rsp_fire || req_fire)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: stretches of open, coin-flip, held-off and sparse ready
	initial begin : rsp_stall_pattern
		stall_t mode;
		int     span;
		rsp_ch.ready <= 1'b0;
		forever begin
			mode = stall_t'($urandom_range(0, 3));
			span = $urandom_range(4, 48);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					RX_OPEN:   rsp_ch.ready <= 1'b1;
					RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
					RX_HOLD:   rsp_ch.ready <= 1'b0;
					default:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Drive one transaction; bursts of back-to-back items with idle gaps between them
	task automatic send(input req_item_t it, input chk_t how);
		int gap;
		check_q = {check_q, how};
		req_ch.valid              <= 1'b1;
		req_ch.kind               <= it.kind;
		req_ch.x_a                <= it.x_a;
		req_ch.y_a                <= it.y_a;
		req_ch.z_a                <= it.z_a;
		req_ch.x_b                <= it.x_b;
		req_ch.y_b                <= it.y_b;
		req_ch.z_b                <= it.z_b;
		req_ch.cell_present       <= it.cell_present;
		req_ch.cell_blocks        <= it.cell_blocks;
		req_ch.require_same_floor <= it.require_same_floor;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
			                                          : $urandom_range(0, 6);
		end
	endtask

	// Hold the sender off until every outstanding answer is back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sight_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int        span_xy, span_z, bx, by, bz, n_wr, n_q, n_noise, next_pause, j;
		int        ax, ay, az;
		req_item_t it;
		arst_n                    <= 1'b0;
		req_ch.valid              <= 1'b0;
		req_ch.kind               <= KIND_WRITE;
		req_ch.x_a                <= '0;
		req_ch.y_a                <= '0;
		req_ch.z_a                <= '0;
		req_ch.x_b                <= '0;
		req_ch.y_b                <= '0;
		req_ch.z_b                <= '0;
		req_ch.cell_present       <= 1'b0;
		req_ch.cell_blocks        <= 1'b0;
		req_ch.require_same_floor <= 1'b0;
		foreach (cell_map[i])
			cell_map[i] = 2'b00;

		// Directed table: kind, a, b, present, blocks, same floor, how checked
		add_row(pack_item(KIND_QUERY, 0, 0, 0, 63, 63, 15, 0, 0, 0), CHK_CLEAR);
		add_row(pack_item(KIND_QUERY, 63, 0, 15, 0, 63, 0, 1, 1, 1), CHK_BLOCKED);
		add_row(pack_item(KIND_WRITE, 0, 0, 0, 0, 0, 0, 1, 1, 0), CHK_MODEL);
		add_row(pack_item(KIND_WRITE, 63, 63, 15, 0, 0, 0, 1, 1, 0), CHK_MODEL);
		add_row(pack_item(KIND_WRITE, 1, 0, 0, 0, 0, 0, 1, 1, 0), CHK_MODEL);
		// adjacent blocking endpoints are both skipped
		add_row(pack_item(KIND_QUERY, 0, 0, 0, 1, 0, 0, 0, 0, 1), CHK_CLEAR);
		// equal endpoints on a blocking cell
		add_row(pack_item(KIND_QUERY, 63, 63, 15, 63, 63, 15, 0, 0, 0), CHK_CLEAR);
		add_row(pack_item(KIND_WRITE, 5, 0, 0, 0, 0, 0, 1, 1, 0), CHK_MODEL);
		add_row(pack_item(KIND_QUERY, 0, 0, 0, 10, 0, 0, 0, 0, 0), CHK_BLOCKED);
		// blocks without present, overwriting a wall
		add_row(pack_item(KIND_WRITE, 5, 0, 0, 0, 0, 0, 0, 1, 0), CHK_MODEL);
		add_row(pack_item(KIND_QUERY, 2, 0, 0, 10, 0, 0, 0, 0, 0), CHK_MODEL);
		add_row(pack_item(KIND_WRITE, 7, 0, 0, 0, 0, 0, 1, 0, 0), CHK_MODEL);
		add_row(pack_item(KIND_QUERY, 10, 0, 0, 2, 0, 0, 0, 0, 1), CHK_MODEL);
		// floor changes over a non-blocking tile
		add_row(pack_item(KIND_WRITE, 20, 20, 0, 0, 0, 0, 1, 0, 0), CHK_MODEL);
		add_row(pack_item(KIND_QUERY, 20, 20, 0, 20, 20, 3, 0, 0, 0), CHK_MODEL);
		add_row(pack_item(KIND_QUERY, 20, 20, 3, 20, 22, 0, 0, 0, 0), CHK_MODEL);
		add_row(pack_item(KIND_QUERY, 21, 20, 1, 19, 21, 0, 0, 0, 0), CHK_MODEL);
		// major axis along y, then major axis ties
		add_row(pack_item(KIND_QUERY, 10, 40, 2, 12, 60, 2, 0, 0, 0), CHK_MODEL);
		add_row(pack_item(KIND_QUERY, 40, 40, 4, 44, 44, 8, 0, 0, 0), CHK_MODEL);
		add_row(pack_item(KIND_QUERY, 40, 40, 4, 40, 44, 8, 0, 0, 0), CHK_MODEL);
		add_row(pack_item(KIND_WRITE, 32, 32, 8, 0, 0, 0, 1, 1, 0), CHK_MODEL);
		add_row(pack_item(KIND_QUERY, 0, 0, 8, 63, 63, 8, 0, 0, 1), CHK_MODEL);
		add_row(pack_item(KIND_WRITE, 63, 63, 15, 0, 0, 0, 0, 0, 0), CHK_MODEL);
		add_row(pack_item(KIND_QUERY, 62, 0, 15, 0, 63, 14, 0, 0, 0), CHK_MODEL);
		// unused destination fields at their top on a write
		add_row(pack_item(KIND_WRITE, 31, 10, 7, 63, 63, 15, 1, 1, 1), CHK_MODEL);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_q[r])
			send(directed_q[r].item, directed_q[r].how);
		drain_results();

		// Random scenes: walls dropped into a box, then sight queries across it
		next_pause = PAUSE_EVERY;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent >= next_pause) begin
				drain_results();
				next_pause += PAUSE_EVERY;
			end
			span_xy = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(3, 15);
			span_z  = ($urandom_range(0, 5) == 0) ? 15 : $urandom_range(0, 2);
			bx      = $urandom_range(0, 63 - span_xy);
			by      = $urandom_range(0, 63 - span_xy);
			bz      = $urandom_range(0, 15 - span_z);
			n_wr    = $urandom_range(2, 12);
			n_q     = $urandom_range(1, 6);
			n_noise = ($urandom_range(0, 2) == 0) ? 1 : 0;
			for (j = 0; j < n_wr; j++) begin
				it = pack_item(KIND_WRITE, bx + $urandom_range(0, span_xy),
					by + $urandom_range(0, span_xy), bz + $urandom_range(0, span_z),
					$urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15),
					$urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
					1'($urandom_range(0, 1)));
				send(it, CHK_MODEL);
				random_sent++;
			end
			for (j = 0; j < n_q; j++) begin
				ax = bx + $urandom_range(0, span_xy);
				ay = by + $urandom_range(0, span_xy);
				az = bz + $urandom_range(0, span_z);
				if ($urandom_range(0, 9) == 0)
					it = pack_item(KIND_QUERY, ax, ay, az, ax, ay, az,
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				else
					it = pack_item(KIND_QUERY, ax, ay, az, bx + $urandom_range(0, span_xy),
						by + $urandom_range(0, span_xy), bz + $urandom_range(0, span_z),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						$urandom_range(0, 3) == 0);
				send(it, CHK_MODEL);
				random_sent++;
			end
			// unstructured transaction anywhere in the grid
			for (j = 0; j < n_noise; j++) begin
				it = pack_item(1'($urandom_range(0, 1)), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 15), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				send(it, CHK_MODEL);
				random_sent++;
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
